/* design/akx_pkg.sv */
// Shared types, constants and round functions for the AES-128 key expansion block.
package akx_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int NUM_KEYS   = NUM_ROUNDS + 1;
  localparam int ROUND_W    = 4;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS);

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } akx_in_t;

  typedef struct packed {
    logic [ROUND_W-1:0] round_number;
    logic [63:0]        round_key_low;
    logic [63:0]        round_key_high;
    logic               last_key;
  } akx_out_t;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Word 0 sits in bits 31:0, with key byte 0 in its low byte.
  function automatic logic [127:0] next_round_key(input logic [127:0] key,
                                                  input logic [7:0]   rcon);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] t;
    w0 = key[31:0];
    w1 = key[63:32];
    w2 = key[95:64];
    w3 = key[127:96];
    t  = sub_word({w3[7:0], w3[31:8]}) ^ {24'h000000, rcon};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage

/* design/akx_cell.sv */
// One stage of the round-key chain: holds one round key and derives it from its neighbor (round 0 loads the input key).
module akx_cell #(
  parameter int ROUND = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         prev_valid,
  input  logic [127:0] prev_key,
  output logic         valid_r,
  output logic [127:0] key_r
);

  logic [127:0] key_nxt;

  generate
    if (ROUND == 0) begin : g_load
      assign key_nxt = prev_key;
    end else begin : g_round
      assign key_nxt = akx_pkg::next_round_key(prev_key, akx_pkg::RCON[ROUND-1]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_valid) begin
      key_r <= key_nxt;
    end
  end

endmodule

/* design/aes128_key_expansion_core.sv */
// AES-128 key expansion top level: a chain of eleven round-key cells and the result selection.
// Round key r of an accepted word passes through cells 0 to r and is shown on the result ports from cell r.
// All eleven round keys come out on consecutive cycles; round 10 carries last_key.
// A new word is not accepted while busy is high, as the output port shows one result per cycle:
// busy drops in the cycle that shows round 10, so the next word's round 0 follows directly.
// Synchronous active-low reset clears every cell's valid bit; key registers are not reset.
module aes128_key_expansion_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  akx_pkg::akx_in_t in_word,
  output logic             busy,
  output logic             out_valid,
  output akx_pkg::akx_out_t out_word
);

  localparam int N = akx_pkg::NUM_KEYS;

  logic [N-1:0] cell_valid;
  logic [127:0] cell_key [N];
  logic         in_accept;

  assign in_accept = start && !busy;

  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
        akx_cell #(.ROUND(0)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .prev_valid (in_accept),
          .prev_key   ({in_word.key_high, in_word.key_low}),
          .valid_r    (cell_valid[0]),
          .key_r      (cell_key[0])
        );
      end else begin : g_body
        akx_cell #(.ROUND(i)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .prev_valid (cell_valid[i-1]),
          .prev_key   (cell_key[i-1]),
          .valid_r    (cell_valid[i]),
          .key_r      (cell_key[i])
        );
      end
    end
  endgenerate

  assign busy      = |cell_valid[N-2:0];
  assign out_valid = |cell_valid;

  always_comb begin
    logic [127:0]                 key_sel;
    logic [akx_pkg::ROUND_W-1:0]  round_sel;
    key_sel   = '0;
    round_sel = '0;
    for (int i = 0; i < N; i++) begin
      key_sel   = key_sel | ({128{cell_valid[i]}} & cell_key[i]);
      round_sel = round_sel | ({akx_pkg::ROUND_W{cell_valid[i]}} & akx_pkg::ROUND_W'(i));
    end
    out_word.round_number   = round_sel;
    out_word.round_key_low  = key_sel[63:0];
    out_word.round_key_high = key_sel[127:64];
    out_word.last_key       = cell_valid[N-1];
  end

endmodule

/* design/akx_checker.sv */
// Port-level checks for the AES-128 key expansion core, bound to the top level.
module akx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input akx_pkg::akx_out_t out_word
);

  a_first_round: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid && out_word.round_number == '0)
    else $error("accepted word did not yield round 0 next cycle");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_key |=>
      out_valid && out_word.round_number == $past(out_word.round_number) + 1'b1)
    else $error("round keys not on consecutive cycles in order");

  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_key |-> busy)
    else $error("busy low in the middle of a run");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.last_key == (out_word.round_number == akx_pkg::LAST_ROUND)))
    else $error("last_key does not match round 10");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_key && !start |=> !out_valid && !busy)
    else $error("results continue after the last round without a new word");

endmodule

bind aes128_key_expansion_core akx_checker u_akx_checker (.*);

/* tb/aes128_key_expansion_core_test.sv */
// Self-checking testbench for the AES-128 key expansion core and its round-key predictor.
module aes128_key_expansion_core_test;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_KEYS  = 470;
  localparam int TAIL_CYCLES  = 30;

  logic              clk;
  logic              rst_n;
  logic              start;
  akx_pkg::akx_in_t  in_word;
  logic              busy;
  logic              out_valid;
  akx_pkg::akx_out_t out_word;

  logic [7:0]        sub_table [256];
  akx_pkg::akx_out_t round_keys_due [$];
  int                keys_sent;
  int                round_keys_checked;
  int                error_count;
  int                idle_cycles;

  aes128_key_expansion_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ a;
      end
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    logic [15:0] d;
    d = {b, b} << n;
    return d[15:8];
  endfunction

  // The substitution table is derived from the field inverse and the affine map.
  function automatic void build_sub_table();
    logic [7:0] inv;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(8'(a), 8'(b)) == 8'h01) begin
          inv = 8'(b);
        end
      end
      sub_table[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
    end
  endfunction

  function automatic logic [31:0] substitute_word(input logic [31:0] w);
    return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
  endfunction

  function automatic void queue_round_keys(input akx_pkg::akx_in_t key);
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic [31:0]       w2;
    logic [31:0]       w3;
    logic [31:0]       t;
    logic [7:0]        rc;
    akx_pkg::akx_out_t rk;
    w0 = key.key_low[31:0];
    w1 = key.key_low[63:32];
    w2 = key.key_high[31:0];
    w3 = key.key_high[63:32];
    rc = 8'h01;
    for (int r = 0; r <= akx_pkg::NUM_ROUNDS; r++) begin
      if (r > 0) begin
        t  = substitute_word({w3[7:0], w3[31:8]}) ^ {24'h000000, rc};
        rc = xtime(rc);
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
      end
      rk.round_number   = akx_pkg::ROUND_W'(r);
      rk.round_key_low  = {w1, w0};
      rk.round_key_high = {w3, w2};
      rk.last_key       = (r == akx_pkg::NUM_ROUNDS);
      round_keys_due.push_back(rk);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    akx_pkg::akx_out_t want;
    if (rst_n && out_valid) begin
      if (round_keys_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_word);
        error_count++;
      end else begin
        want = round_keys_due.pop_front();
        check_field("round_number", 64'(want.round_number), 64'(out_word.round_number));
        check_field("round_key_low", want.round_key_low, out_word.round_key_low);
        check_field("round_key_high", want.round_key_high, out_word.round_key_high);
        check_field("last_key", 64'(want.last_key), 64'(out_word.last_key));
        round_keys_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] random64();
    return {$urandom(), $urandom()};
  endfunction

  // Mixes dense, sparse and uniform patterns so that runs of equal bytes appear too.
  function automatic logic [63:0] shaped64();
    case ($urandom_range(0, 3))
      0: return random64() & random64() & random64();
      1: return random64() | random64() | random64();
      2: return {8{8'($urandom())}};
      default: return random64();
    endcase
  endfunction

  task automatic send_key(input logic [63:0] low, input logic [63:0] high);
    @(negedge clk);
    start            = 1'b1;
    in_word.key_low  = low;
    in_word.key_high = high;
    do begin
      @(posedge clk);
    end while (busy);
    queue_round_keys(in_word);
    keys_sent++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start   = 1'b0;
      in_word = {random64(), random64()};
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (round_keys_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_keys();
    send_key(64'h0000000000000000, 64'h0000000000000000);
    hold_off(3);
    send_key(64'hffffffffffffffff, 64'hffffffffffffffff);
    hold_off(1);
    send_key(64'ha6d2ae2816157e2b, 64'h3c4fcf098815f7ab);
    send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    hold_off(7);
    send_key(64'hffffffffffffffff, 64'h0000000000000000);
    send_key(64'h0000000000000000, 64'hffffffffffffffff);
    send_key(64'h0000000000000000, 64'h8000000000000000);
    send_key(64'h0000000000000001, 64'h0000000000000000);
    send_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    hold_off(2);
  endtask

  task automatic test_back_to_back();
    repeat (6) send_key(random64(), random64());
  endtask

  task automatic test_drained_restart();
    hold_off(1);
    wait_for_drain();
    send_key(random64(), random64());
    hold_off(1);
    wait_for_drain();
  endtask

  task automatic test_random_bursts(input int total);
    int burst;
    int sent;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < total; i++) begin
        send_key(shaped64(), shaped64());
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        hold_off($urandom_range(20, 40));
      end else begin
        hold_off($urandom_range(0, 12));
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    in_word            = '0;
    keys_sent          = 0;
    round_keys_checked = 0;
    error_count        = 0;
    idle_cycles        = 0;
    build_sub_table();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_corner_keys();
    test_back_to_back();
    test_drained_restart();
    test_random_bursts(RANDOM_KEYS);

    hold_off(1);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Expanded %0d cipher keys and checked %0d round keys,", keys_sent,
             round_keys_checked);
    $display("covering corner keys, back-to-back starts, a drained restart and random bursts.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
